>>> rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, constants, types and helpers for the barometric pressure
// compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  // External field widths
  localparam int COEF_W   = 16;
  localparam int ADC_W    = 24;
  localparam int TEMP_W   = 16;
  localparam int PRES_W   = 18;
  localparam int NUM_COEF = 6;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 40;

  // Internal datapath widths
  localparam int DT_W   = 26;  // dT = D2 - c5*256
  localparam int TMP_W  = 20;  // temperature before saturation
  localparam int OFF_W  = 40;  // OFF and SENS after correction
  localparam int SQ_W   = 36;  // squared temperature terms
  localparam int CORR_W = 38;  // OFF2 / SENS2
  localparam int T2_W   = 17;  // dT^2 / 2^31
  localparam int MUL_W  = 27;  // shared multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 64;  // D1 * SENS
  localparam int PT_W   = 44;  // D1*SENS/2^21 - OFF
  localparam int SPLIT  = 20;  // SENS split point for the two partial products

  // Compensation constants
  localparam int TEMP_REF  = 2000;
  localparam int TEMP_COLD = -1500;
  localparam int TEMP_MIN  = -32768;
  localparam int TEMP_MAX  = 32767;
  localparam int PRESS_MAX = 262143;

  // Register map indexes
  typedef enum logic [2:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } bpc_reg_t;

  // Calibration words
  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } bpc_coef_t;

  // Operand pair for the shared multiplier
  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } bpc_mul_req_t;

  // Arithmetic shift right by sh that rounds toward zero
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v,
                                                   input logic [5:0] sh);
    logic signed [63:0] q;
    logic [63:0]        mask;
    q    = v >>> sh;
    mask = ~(64'hFFFF_FFFF_FFFF_FFFF << sh);
    if (v[63] && (($unsigned(v) & mask) != 64'd0)) q = q + 64'sd1;
    return q;
  endfunction

endpackage

`default_nettype wire

>>> rtl/baro_temp_pressure_compensation.sv
// Sequence: an accepted reading passes through 13 sequencer steps before its
//   result shows on out_tvalid; the last step loads the output register.
// Sharing: one reading is taken at a time; the shared 27x27 multiplier is
//   used for eight products in turn, and in_tready is high only when idle.
// Reset: synchronous active-low rst_n clears the calibration words, both raw
//   readings, the phase (first reading is pressure) and the output valid.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Second-order temperature and pressure compensation for a barometric
// sensor fed with alternating raw pressure and temperature conversions.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_temp_pressure_compensation
  import bpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // [23:0] adc_value
  // Result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,  // [15:0] temperature_centideg,
                                             // [33:16] pressure_pa, [39:34] zero
  output logic                   out_tuser,  // [0] reading_kind
  // Configuration port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  bpc_coef_t                coef;
  bpc_mul_req_t             mul_req;
  logic signed [PROD_W-1:0] prod;
  logic [TEMP_W-1:0]        res_temp;
  logic [PRES_W-1:0]        res_pres;

  assign cfg_pready = 1'b1;

  // Calibration registers
  bpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .coef    (coef)
  );

  // Shared multiplier
  bpc_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod)
  );

  // Sequencer and datapath
  bpc_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef       (coef),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_adc     (in_tdata[ADC_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_temp   (res_temp),
    .out_pres   (res_pres),
    .out_kind   (out_tuser),
    .mul_req    (mul_req),
    .prod_r     (prod)
  );

  assign out_tdata = {{(OUT_DW-TEMP_W-PRES_W){1'b0}}, res_pres, res_temp};

endmodule

`default_nettype wire

>>> rtl/bpc_cfg.sv
// ----------------------------------------------------------------------------
// bpc_cfg
// Calibration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_cfg
  import bpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output bpc_coef_t              coef
);

  bpc_coef_t        coef_r;
  logic [2:0]       idx;
  logic             wr_en;
  logic [COEF_W-1:0] wval;

  assign idx   = paddr[CFG_AW-1:2];
  assign wr_en = psel & penable & pwrite;
  assign wval  = pwdata[COEF_W-1:0];

  // Register writes; indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_C1:  coef_r.c1 <= wval;
        REG_C2:  coef_r.c2 <= wval;
        REG_C3:  coef_r.c3 <= wval;
        REG_C4:  coef_r.c4 <= wval;
        REG_C5:  coef_r.c5 <= wval;
        REG_C6:  coef_r.c6 <= wval;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_C1:  prdata = {{(CFG_DW-COEF_W){1'b0}}, coef_r.c1};
      REG_C2:  prdata = {{(CFG_DW-COEF_W){1'b0}}, coef_r.c2};
      REG_C3:  prdata = {{(CFG_DW-COEF_W){1'b0}}, coef_r.c3};
      REG_C4:  prdata = {{(CFG_DW-COEF_W){1'b0}}, coef_r.c4};
      REG_C5:  prdata = {{(CFG_DW-COEF_W){1'b0}}, coef_r.c5};
      REG_C6:  prdata = {{(CFG_DW-COEF_W){1'b0}}, coef_r.c6};
      default: prdata = '0;
    endcase
  end

  assign coef = coef_r;

endmodule

`default_nettype wire

>>> rtl/bpc_mul.sv
// ----------------------------------------------------------------------------
// bpc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_mul
  import bpc_pkg::*;
(
  input  wire logic               clk,
  input  wire bpc_mul_req_t       req,
  output logic signed [PROD_W-1:0] prod_r
);

  // One product per cycle, registered in the cycle after the operands
  always_ff @(posedge clk) begin
    prod_r <= $signed(req.a) * $signed(req.b);
  end

endmodule

`default_nettype wire

>>> rtl/bpc_seq.sv
// ----------------------------------------------------------------------------
// bpc_seq
// Sequencer and datapath registers: stores the raw readings, steps the
// shared multiplier through the compensation terms and holds the result
// in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_seq
  import bpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpc_coef_t          coef,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [ADC_W-1:0]   in_adc,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TEMP_W-1:0]       out_temp,
  output logic [PRES_W-1:0]       out_pres,
  output logic                    out_kind,
  output bpc_mul_req_t            mul_req,
  input  wire logic signed [PROD_W-1:0] prod_r
);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'h0001,
    ST_TEMP  = 14'h0002,
    ST_OFF   = 14'h0004,
    ST_SENS  = 14'h0008,
    ST_DT2   = 14'h0010,
    ST_D2    = 14'h0020,
    ST_E2    = 14'h0040,
    ST_CORR  = 14'h0080,
    ST_APPLY = 14'h0100,
    ST_PLO   = 14'h0200,
    ST_PHI   = 14'h0400,
    ST_PSUM  = 14'h0800,
    ST_PDIV  = 14'h1000,
    ST_FIN   = 14'h2000
  } bpc_state_t;

  bpc_state_t state_r, state_nxt;

  // Control state
  logic              next_is_temp_r, next_is_temp_nxt;
  logic [ADC_W-1:0]  praw_r, praw_nxt;
  logic [ADC_W-1:0]  traw_r, traw_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers
  logic signed [DT_W-1:0]  dt_r, dt_nxt;
  logic                    kind_r, kind_nxt;
  logic signed [TMP_W-1:0] temp_r, temp_nxt;
  logic signed [OFF_W-1:0] off_r, off_nxt;
  logic signed [OFF_W-1:0] sens_r, sens_nxt;
  logic [T2_W-1:0]         t2_r, t2_nxt;
  logic [CORR_W-1:0]       off2_r, off2_nxt;
  logic [CORR_W-1:0]       sens2_r, sens2_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [PT_W-1:0]  pt_r, pt_nxt;
  logic [TEMP_W-1:0]       otemp_r, otemp_nxt;
  logic [PRES_W-1:0]       opres_r, opres_nxt;
  logic                    okind_r, okind_nxt;

  // Datapath intermediates
  logic                    in_acc;
  logic                    out_free;
  logic [ADC_W-1:0]        traw_new;
  logic signed [63:0]      prod64;
  logic signed [63:0]      sum64;
  logic signed [63:0]      q15;
  logic signed [TMP_W-1:0] d_val;
  logic signed [TMP_W-1:0] e_val;
  logic [SQ_W-1:0]         sq;
  logic [CORR_W-1:0]       five_sq;
  logic [CORR_W-1:0]       seven_sq;
  logic [CORR_W-1:0]       eleven_sq;
  logic                    is_cold;
  logic                    is_very_cold;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_temp   = otemp_r;
  assign out_pres   = opres_r;
  assign out_kind   = okind_r;

  assign traw_new = next_is_temp_r ? in_adc : traw_r;
  assign prod64   = {{(64-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign d_val    = temp_r - TMP_W'(TEMP_REF);
  assign e_val    = temp_r - TMP_W'(TEMP_COLD);
  assign sq       = prod_r[SQ_W-1:0];
  assign five_sq  = {sq, 2'b00} + {2'b00, sq};
  assign seven_sq = {sq[SQ_W-2:0], 3'b000} - {2'b00, sq};
  assign eleven_sq = {sq[SQ_W-2:0], 3'b000} + {1'b0, sq, 1'b0} + {2'b00, sq};
  assign is_cold      = temp_r < TMP_W'(TEMP_REF);
  assign is_very_cold = temp_r < TMP_W'(TEMP_COLD);

  // Multiplier operand select
  always_comb begin
    mul_req = '0;
    case (state_r)
      ST_TEMP: begin
        mul_req.a = {dt_r[DT_W-1], dt_r};
        mul_req.b = {{(MUL_W-COEF_W){1'b0}}, coef.c6};
      end
      ST_OFF: begin
        mul_req.a = {dt_r[DT_W-1], dt_r};
        mul_req.b = {{(MUL_W-COEF_W){1'b0}}, coef.c4};
      end
      ST_SENS: begin
        mul_req.a = {dt_r[DT_W-1], dt_r};
        mul_req.b = {{(MUL_W-COEF_W){1'b0}}, coef.c3};
      end
      ST_DT2: begin
        mul_req.a = {dt_r[DT_W-1], dt_r};
        mul_req.b = {dt_r[DT_W-1], dt_r};
      end
      ST_D2: begin
        mul_req.a = {{(MUL_W-TMP_W){d_val[TMP_W-1]}}, d_val};
        mul_req.b = {{(MUL_W-TMP_W){d_val[TMP_W-1]}}, d_val};
      end
      ST_E2: begin
        mul_req.a = {{(MUL_W-TMP_W){e_val[TMP_W-1]}}, e_val};
        mul_req.b = {{(MUL_W-TMP_W){e_val[TMP_W-1]}}, e_val};
      end
      ST_PLO: begin
        mul_req.a = {{(MUL_W-ADC_W){1'b0}}, praw_r};
        mul_req.b = {{(MUL_W-SPLIT){1'b0}}, sens_r[SPLIT-1:0]};
      end
      ST_PHI: begin
        mul_req.a = {{(MUL_W-ADC_W){1'b0}}, praw_r};
        mul_req.b = {{(MUL_W-(OFF_W-SPLIT)){sens_r[OFF_W-1]}}, sens_r[OFF_W-1:SPLIT]};
      end
      default: mul_req = '0;
    endcase
  end

  // Next state and datapath updates
  always_comb begin
    state_nxt        = state_r;
    next_is_temp_nxt = next_is_temp_r;
    praw_nxt         = praw_r;
    traw_nxt         = traw_r;
    out_valid_nxt    = out_valid_r & ~out_tready;
    dt_nxt           = dt_r;
    kind_nxt         = kind_r;
    temp_nxt         = temp_r;
    off_nxt          = off_r;
    sens_nxt         = sens_r;
    t2_nxt           = t2_r;
    off2_nxt         = off2_r;
    sens2_nxt        = sens2_r;
    acc_nxt          = acc_r;
    pt_nxt           = pt_r;
    otemp_nxt        = otemp_r;
    opres_nxt        = opres_r;
    okind_nxt        = okind_r;
    sum64            = '0;
    q15              = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (next_is_temp_r) traw_nxt = in_adc;
          else                praw_nxt = in_adc;
          next_is_temp_nxt = ~next_is_temp_r;
          kind_nxt         = next_is_temp_r;
          dt_nxt = $signed({2'b00, traw_new}) - $signed({2'b00, coef.c5, 8'h00});
          state_nxt = ST_TEMP;
        end
      end
      ST_TEMP: state_nxt = ST_OFF;
      ST_OFF: begin
        // TEMP = 2000 + dT*c6/2^23
        sum64     = trunc_shr(prod64, 6'd23) + 64'sd2000;
        temp_nxt  = sum64[TMP_W-1:0];
        state_nxt = ST_SENS;
      end
      ST_SENS: begin
        // OFF = c2*2^16 + c4*dT/2^7
        sum64     = $signed({32'd0, coef.c2, 16'h0000}) + trunc_shr(prod64, 6'd7);
        off_nxt   = sum64[OFF_W-1:0];
        state_nxt = ST_DT2;
      end
      ST_DT2: begin
        // SENS = c1*2^15 + c3*dT/2^8
        sum64     = $signed({33'd0, coef.c1, 15'h0000}) + trunc_shr(prod64, 6'd8);
        sens_nxt  = sum64[OFF_W-1:0];
        state_nxt = ST_D2;
      end
      ST_D2: begin
        // T2 = dT^2/2^31, never negative
        t2_nxt    = prod_r[31+T2_W-1:31];
        state_nxt = ST_E2;
      end
      ST_E2: begin
        // OFF2 = 5*d^2/2
        off2_nxt  = five_sq >> 1;
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        // SENS2 = OFF2/2, very cold adds 7*e^2 and 11*e^2/2
        off2_nxt  = off2_r + (is_very_cold ? seven_sq : '0);
        sens2_nxt = (off2_r >> 1) + (is_very_cold ? (eleven_sq >> 1) : '0);
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (is_cold) begin
          temp_nxt = temp_r - $signed({{(TMP_W-T2_W){1'b0}}, t2_r});
          off_nxt  = off_r - $signed({{(OFF_W-CORR_W){1'b0}}, off2_r});
          sens_nxt = sens_r - $signed({{(OFF_W-CORR_W){1'b0}}, sens2_r});
        end
        state_nxt = ST_PLO;
      end
      ST_PLO: state_nxt = ST_PHI;
      ST_PHI: begin
        // Low partial product is unsigned
        acc_nxt   = $signed({{(ACC_W-PROD_W){1'b0}}, prod_r});
        state_nxt = ST_PSUM;
      end
      ST_PSUM: begin
        acc_nxt   = acc_r + (prod64 <<< SPLIT);
        state_nxt = ST_PDIV;
      end
      ST_PDIV: begin
        sum64     = trunc_shr(acc_r, 6'd21) - {{(64-OFF_W){off_r[OFF_W-1]}}, off_r};
        pt_nxt    = sum64[PT_W-1:0];
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // Saturate and load the output register once it is free
        if (out_free) begin
          q15 = trunc_shr({{(64-PT_W){pt_r[PT_W-1]}}, pt_r}, 6'd15);
          if (temp_r < TMP_W'(TEMP_MIN))      otemp_nxt = TEMP_W'(TEMP_MIN);
          else if (temp_r > TMP_W'(TEMP_MAX)) otemp_nxt = TEMP_W'(TEMP_MAX);
          else                                 otemp_nxt = temp_r[TEMP_W-1:0];
          if (q15 < 64'sd0)                    opres_nxt = '0;
          else if (q15 > 64'(PRESS_MAX))       opres_nxt = PRES_W'(PRESS_MAX);
          else                                 opres_nxt = q15[PRES_W-1:0];
          okind_nxt     = kind_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      next_is_temp_r <= 1'b0;
      praw_r         <= '0;
      traw_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      next_is_temp_r <= next_is_temp_nxt;
      praw_r         <= praw_nxt;
      traw_r         <= traw_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dt_r    <= dt_nxt;
    kind_r  <= kind_nxt;
    temp_r  <= temp_nxt;
    off_r   <= off_nxt;
    sens_r  <= sens_nxt;
    t2_r    <= t2_nxt;
    off2_r  <= off2_nxt;
    sens2_r <= sens2_nxt;
    acc_r   <= acc_nxt;
    pt_r    <= pt_nxt;
    otemp_r <= otemp_nxt;
    opres_r <= opres_nxt;
    okind_r <= okind_nxt;
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_TEMP)
    else $error("accepted beat did not start the sequence");

  a_phase_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> next_is_temp_r != $past(next_is_temp_r))
    else $error("reading phase did not alternate");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result appeared outside the finish step");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && out_valid_r && !out_tready |=> state_r == ST_FIN)
    else $error("finish step overwrote a pending result");

endmodule

`default_nettype wire

>>> bench/baro_comp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_comp_checker
// Watches the reading, result and configuration channels of the barometric
// compensation block. Keeps its own copy of the calibration words and raw
// readings, computes each compensated result and compares it beat by beat.
// ----------------------------------------------------------------------------
module baro_comp_checker
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic              out_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic [CFG_DW-1:0] cfg_prdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                results_owed,
  output int                readings_seen,
  output int                cold_seen,
  output int                very_cold_seen,
  output int                clipped_seen
);

  // Power-of-two divisors of the compensation formulas
  localparam longint DIV_T    = 64'sd8388608;     // 2^23
  localparam longint DIV_T2   = 64'sd2147483648;  // 2^31
  localparam longint DIV_OFF  = 64'sd128;         // 2^7
  localparam longint DIV_SENS = 64'sd256;         // 2^8
  localparam longint DIV_P1   = 64'sd2097152;     // 2^21
  localparam longint DIV_P2   = 64'sd32768;       // 2^15

  localparam int PAD_LSB = TEMP_W + PRES_W;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic [PRES_W-1:0]        pres;
    logic                     kind;
  } comp_result_t;

  logic [COEF_W-1:0] cal_word [NUM_COEF];
  logic              next_temp;
  logic [ADC_W-1:0]  raw_pres;
  logic [ADC_W-1:0]  raw_temp;
  comp_result_t      owed_results [$];
  int                owed_count;
  int                n_fail, n_read, n_cold, n_very_cold, n_clip;

  assign fail_count     = n_fail;
  assign results_owed   = owed_count;
  assign readings_seen  = n_read;
  assign cold_seen      = n_cold;
  assign very_cold_seen = n_very_cold;
  assign clipped_seen   = n_clip;

  initial begin
    n_fail      = 0;
    n_read      = 0;
    n_cold      = 0;
    n_very_cold = 0;
    n_clip      = 0;
    owed_count  = 0;
  end

  // Store the reading in its slot, flip the phase and compensate
  function automatic comp_result_t compensate_reading(input logic [ADC_W-1:0] adc);
    comp_result_t r;
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, tc, off, sens, pres, d, t2, off2, sens2, e;
    r.kind = next_temp;
    if (next_temp) raw_temp = adc;
    else raw_pres = adc;
    next_temp = ~next_temp;

    d1 = raw_pres;
    d2 = raw_temp;
    c1 = cal_word[REG_C1];
    c2 = cal_word[REG_C2];
    c3 = cal_word[REG_C3];
    c4 = cal_word[REG_C4];
    c5 = cal_word[REG_C5];
    c6 = cal_word[REG_C6];

    // first-order terms, every division truncates toward zero
    dt   = d2 - c5 * 256;
    tc   = TEMP_REF + dt * c6 / DIV_T;
    off  = c2 * 65536 + c4 * dt / DIV_OFF;
    sens = c1 * 32768 + c3 * dt / DIV_SENS;

    // second-order correction below 20 C, extra term below -15 C
    if (tc < TEMP_REF) begin
      n_cold++;
      d     = tc - TEMP_REF;
      t2    = dt * dt / DIV_T2;
      off2  = 5 * d * d / 2;
      sens2 = off2 / 2;
      if (tc < TEMP_COLD) begin
        n_very_cold++;
        e     = tc - TEMP_COLD;
        off2  = off2 + 7 * e * e;
        sens2 = sens2 + 11 * e * e / 2;
      end
      tc   = tc - t2;
      off  = off - off2;
      sens = sens - sens2;
    end

    pres = (d1 * sens / DIV_P1 - off) / DIV_P2;

    // saturate to the output ranges
    if (tc < TEMP_MIN || tc > TEMP_MAX || pres < 0 || pres > PRESS_MAX) n_clip++;
    if (tc < TEMP_MIN) tc = TEMP_MIN;
    else if (tc > TEMP_MAX) tc = TEMP_MAX;
    if (pres < 0) pres = 0;
    else if (pres > PRESS_MAX) pres = PRESS_MAX;

    r.temp = tc[TEMP_W-1:0];
    r.pres = pres[PRES_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    comp_result_t want;
    logic [2:0]   idx;
    if (!rst_n) begin
      foreach (cal_word[i]) cal_word[i] = '0;
      next_temp = 1'b0;
      raw_pres  = '0;
      raw_temp  = '0;
      owed_results.delete();
      owed_count <= 0;
    end else begin
      // configuration port: track writes, check read-back
      if (cfg_psel && cfg_penable && cfg_pready) begin
        idx = cfg_paddr[CFG_AW-1:2];
        if (cfg_pwrite) begin
          if (idx < NUM_COEF) cal_word[idx] = cfg_pwdata[COEF_W-1:0];
        end else if (idx < NUM_COEF &&
                     cfg_prdata !== {{(CFG_DW-COEF_W){1'b0}}, cal_word[idx]}) begin
          n_fail++;
          $display("%0t: register %0d read mismatch: expected %h, got %h",
                   $time, idx, cal_word[idx], cfg_prdata);
        end
      end

      // result beat against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          n_fail++;
          $display("%0t: result beat with nothing expected: expected none, got %h/%b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = owed_results.pop_front();
          if (out_tdata[TEMP_W-1:0] !== want.temp) begin
            n_fail++;
            $display("%0t: temperature mismatch: expected %0d, got %0d", $time,
                     want.temp, $signed(out_tdata[TEMP_W-1:0]));
          end
          if (out_tdata[TEMP_W +: PRES_W] !== want.pres) begin
            n_fail++;
            $display("%0t: pressure mismatch: expected %0d, got %0d", $time,
                     want.pres, out_tdata[TEMP_W +: PRES_W]);
          end
          if (out_tdata[OUT_DW-1:PAD_LSB] !== '0) begin
            n_fail++;
            $display("%0t: tdata padding mismatch: expected 0, got %h", $time,
                     out_tdata[OUT_DW-1:PAD_LSB]);
          end
          if (out_tuser !== want.kind) begin
            n_fail++;
            $display("%0t: reading kind mismatch: expected %b, got %b", $time,
                     want.kind, out_tuser);
          end
        end
      end

      // reading beat
      if (in_tvalid && in_tready) begin
        n_read++;
        owed_results.push_back(compensate_reading(in_tdata[ADC_W-1:0]));
      end
      owed_count <= owed_results.size();
    end
  end

endmodule

>>> bench/baro_temp_pressure_compensation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_test
// Drives alternating raw pressure and temperature readings into the
// compensation block under several calibration sets, with random stalls on
// both streams; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_test;
  import bpc_pkg::*;

  localparam int RAND_SETS        = 8;
  localparam int READINGS_PER_SET = 210;
  localparam longint ADC_TOP      = (64'sd1 << ADC_W) - 1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;     // [23:0] adc_value
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;         // [15:0] temperature, [33:16] pressure
  logic              out_tuser;         // [0] reading_kind
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int fail_count, results_owed, readings_seen, cold_seen, very_cold_seen, clipped_seen;

  logic              idle_on = 1'b0;
  int                stall_left = 0;
  logic              next_is_temp = 1'b0;
  logic [COEF_W-1:0] cal_set [NUM_COEF] = '{default: '0};
  int                sets_loaded = 0;

  always #10 clk = ~clk;

  baro_temp_pressure_compensation dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  baro_comp_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .fail_count     (fail_count),
    .results_owed   (results_owed),
    .readings_seen  (readings_seen),
    .cold_seen      (cold_seen),
    .very_cold_seen (very_cold_seen),
    .clipped_seen   (clipped_seen)
  );

  // Result-side backpressure: out_tready drops in random bursts while idle_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // One APB transfer: setup phase, access phase, then a bus-idle phase
  task automatic apb_xfer(input logic wr, input logic [CFG_AW-1:0] addr,
                          input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write all calibration words with junk in the unused bits, poke the two
  // unmapped slots, then read every word back
  task automatic load_calibration();
    logic [CFG_AW-1:0] addr;
    logic [15:0]       junk;
    for (int i = 0; i < NUM_COEF + 2; i++) begin
      addr = CFG_AW'(4 * i);
      junk = 16'($urandom_range(0, 65535));
      if (i < NUM_COEF) apb_xfer(1'b1, addr, {junk, cal_set[i]});
      else apb_xfer(1'b1, addr, $urandom);
    end
    for (int i = 0; i < NUM_COEF; i++) begin
      addr = CFG_AW'(4 * i);
      apb_xfer(1'b0, addr, '0);
    end
    sets_loaded++;
  endtask

  task automatic set_calibration(input logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6);
    cal_set[REG_C1] = c1;
    cal_set[REG_C2] = c2;
    cal_set[REG_C3] = c3;
    cal_set[REG_C4] = c4;
    cal_set[REG_C5] = c5;
    cal_set[REG_C6] = c6;
    load_calibration();
  endtask

  // Present one reading and hold it until the beat is taken
  task automatic send_reading(input logic [ADC_W-1:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    next_is_temp = ~next_is_temp;
  endtask

  task automatic send_pair(input logic [ADC_W-1:0] p, input logic [ADC_W-1:0] t);
    send_reading(p);
    send_reading(t);
  endtask

  // Stop sending until every owed result has come out
  task automatic quiesce();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Temperature readings land near the reference point so that warm, cold
  // and very cold cases all come up; pressure readings sit in a sane band
  function automatic logic [ADC_W-1:0] pick_reading();
    longint center, span, v;
    if ($urandom_range(0, 7) == 0) return ADC_W'($urandom);
    if (!next_is_temp) return ADC_W'($urandom_range(24'h200000, 24'hE00000));
    center = cal_set[REG_C5];
    center = center * 256;
    case ($urandom_range(0, 3))
      0:       span = 64'sd1 << 14;
      1:       span = 64'sd1 << 18;
      2:       span = 64'sd1 << 21;
      default: span = 64'sd1 << 23;
    endcase
    v = center + longint'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    else if (v > ADC_TOP) v = ADC_TOP;
    return v[ADC_W-1:0];
  endfunction

  // Main stimulus
  initial begin
    int mode;
    repeat (5) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on <= 1'b1;
    @(posedge clk);

    // calibration still at reset: pressure comes before any temperature
    send_pair(24'hFFFFFF, 24'h000000);
    send_pair(24'hAAAAAA, 24'h555555);
    quiesce();

    // typical calibration: warm, cold, very cold, clipped cold, zero pressure
    set_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    send_pair(24'd9085466, 24'd8569150);
    send_pair(24'd9085466, 24'd8000000);
    send_pair(24'd9085466, 24'd7000000);
    send_pair(24'd9085466, 24'd0);
    send_pair(24'd0, 24'd8569150);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    quiesce();

    // every word at its top value
    set_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'h000000, 24'h000000);
    quiesce();

    // zero reference point: hot side clips temperature and pressure high
    set_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    quiesce();

    set_calibration(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pair(24'h123456, 24'h654321);

    // random calibration sets, each with a stream of shaped readings
    for (int s = 0; s < RAND_SETS; s++) begin
      quiesce();
      idle_on <= (s != RAND_SETS - 1) && ($urandom_range(0, 3) != 0);
      mode = $urandom_range(0, 2);
      foreach (cal_set[i]) begin
        case (mode)
          0:       cal_set[i] = COEF_W'($urandom_range(0, 65535));
          1:       cal_set[i] = COEF_W'($urandom_range(20000, 60000));
          default: cal_set[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
      end
      load_calibration();
      for (int k = 0; k < READINGS_PER_SET; k++) begin
        if (k == READINGS_PER_SET / 2) quiesce();
        send_reading(pick_reading());
      end
    end

    quiesce();
    repeat (30) @(posedge clk);
    $display("Checked %0d readings under %0d calibration sets: %0d cold (%0d very cold),",
             readings_seen, sets_loaded, cold_seen, very_cold_seen);
    $display("%0d results saturated, %0d mismatches.", clipped_seen, fail_count);
    if (fail_count == 0 && results_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still owed", results_owed);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> baro_temp_pressure_compensation.f
rtl/bpc_pkg.sv
rtl/bpc_cfg.sv
rtl/bpc_mul.sv
rtl/bpc_seq.sv
rtl/baro_temp_pressure_compensation.sv
bench/baro_comp_checker.sv
bench/baro_temp_pressure_compensation_test.sv
